FILE: rtl/framed_spi_handshake_exchanger_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed handshake exchanger
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef FRAMED_SPI_HANDSHAKE_EXCHANGER_ASSERT_SVH
`define FRAMED_SPI_HANDSHAKE_EXCHANGER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FSHE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("exchanger check failed");

// antecedent implies consequent in the next cycle
`define FSHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("exchanger check failed");

`endif

FILE: rtl/fshe_pkg.sv
// ---------------------------------------------------------------------------
// fshe_pkg
// Types, codes and the transmit frame layout of the handshake exchanger.
// ---------------------------------------------------------------------------
`default_nettype none

package fshe_pkg;

  localparam int unsigned FRAME_LEN = 10;

  typedef logic [3:0]  idx_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  // frame markers
  localparam byte_t TX_SOF = 8'hFB;
  localparam byte_t TX_EOF = 8'hFF;
  localparam byte_t RX_SOF = 8'hFA;
  localparam byte_t RX_EOF = 8'hFE;

  // register reset values
  localparam word_t PRESCALE_RST = 16'd100;
  localparam byte_t TIMEOUT_RST  = 8'd10;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PRESCALE = 3'd0,
    CFG_TIMEOUT  = 3'd1,
    CFG_TURNS    = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_STEP     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    word_t prescale_limit;
    byte_t timeout_limit;
    word_t turn_count;
    word_t coil_length;
    word_t step_size;
  } cfg_t;

  // one tick request
  typedef struct packed {
    word_t status_bits;
    logic  partner_ack;
    byte_t rx_byte;
  } in_req_t;

  // one slot result
  typedef struct packed {
    byte_t tx_byte;
    logic  rx_taken;
    logic  ack_request;
    byte_t staged_byte;
    word_t windings;
    word_t speed_rpm;
    word_t progress;
    word_t tension;
    logic  frame_done;
  } out_res_t;

  // transmit frame byte at an index; out-of-range reads as byte 0
  function automatic byte_t frame_byte(idx_t idx, word_t status, cfg_t cfg);
    byte_t b;
    case (idx)
      4'd0:    b = TX_SOF;
      4'd1:    b = status[15:8];
      4'd2:    b = status[7:0];
      4'd3:    b = cfg.turn_count[15:8];
      4'd4:    b = cfg.turn_count[7:0];
      4'd5:    b = cfg.coil_length[15:8];
      4'd6:    b = cfg.coil_length[7:0];
      4'd7:    b = cfg.step_size[15:8];
      4'd8:    b = cfg.step_size[7:0];
      4'd9:    b = TX_EOF;
      default: b = TX_SOF;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fshe_if.sv
// ---------------------------------------------------------------------------
// fshe channel interfaces
// Valid/ready channels for tick requests and slot results.
// ---------------------------------------------------------------------------
`default_nettype none

interface fshe_in_if;
  logic                 valid;
  logic                 ready;
  fshe_pkg::word_t      status_bits;
  logic                 partner_ack;
  fshe_pkg::byte_t      rx_byte;

  modport source (output valid, output status_bits, output partner_ack,
                  output rx_byte, input ready);
  modport sink   (input valid, input status_bits, input partner_ack,
                  input rx_byte, output ready);
endinterface

interface fshe_out_if;
  logic                 valid;
  logic                 ready;
  fshe_pkg::byte_t      tx_byte;
  logic                 rx_taken;
  logic                 ack_request;
  fshe_pkg::byte_t      staged_byte;
  fshe_pkg::word_t      windings;
  fshe_pkg::word_t      speed_rpm;
  fshe_pkg::word_t      progress;
  fshe_pkg::word_t      tension;
  logic                 frame_done;

  modport source (output valid, output tx_byte, output rx_taken, output ack_request,
                  output staged_byte, output windings, output speed_rpm,
                  output progress, output tension, output frame_done, input ready);
  modport sink   (input valid, input tx_byte, input rx_taken, input ack_request,
                  input staged_byte, input windings, input speed_rpm,
                  input progress, input tension, input frame_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/framed_spi_handshake_exchanger.sv
// ---------------------------------------------------------------------------
// framed_spi_handshake_exchanger
// Prescaled frame slots with toggle handshake byte exchange over a link.
// ---------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | status_bits, partner_ack, rx_byte
//  out_ch  | out | valid / ready    | tx_byte .. frame_done (one per fired slot)
//  cfg_*   | in  | cfg_we           | cfg_index, cfg_wdata
//
// One tick request is taken per cycle while in_ch.ready is high; it is registered,
// then the slot unit updates state and, for a firing slot, loads the result
// register. Ticks that fire no slot give no result. Synchronous active-low
// reset clears the valid flags and slot state and restores register defaults.
// A stalled result holds the slot stage; non-firing ticks still pass.
// ---------------------------------------------------------------------------
`default_nettype none

module framed_spi_handshake_exchanger (
  input  wire logic         clk,
  input  wire logic         rst_n,
  fshe_in_if.sink           in_ch,
  fshe_out_if.source        out_ch,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);

  fshe_pkg::cfg_t     cfg_r;
  fshe_pkg::in_req_t  s1_req_r;
  logic               s1_valid_r;
  fshe_pkg::out_res_t out_res_r;
  logic               out_valid_r;

  fshe_pkg::out_res_t slot_res;
  logic               slot_fire;
  logic               out_free;
  logic               s1_process;
  logic               out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale_limit <= fshe_pkg::PRESCALE_RST;
      cfg_r.timeout_limit  <= fshe_pkg::TIMEOUT_RST;
      cfg_r.turn_count     <= '0;
      cfg_r.coil_length    <= '0;
      cfg_r.step_size      <= '0;
    end else if (cfg_we) begin
      case (fshe_pkg::cfg_idx_t'(cfg_index))
        fshe_pkg::CFG_PRESCALE: cfg_r.prescale_limit <= cfg_wdata;
        fshe_pkg::CFG_TIMEOUT:  cfg_r.timeout_limit  <= cfg_wdata[7:0];
        fshe_pkg::CFG_TURNS:    cfg_r.turn_count     <= cfg_wdata;
        fshe_pkg::CFG_LENGTH:   cfg_r.coil_length    <= cfg_wdata;
        fshe_pkg::CFG_STEP:     cfg_r.step_size      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage flow control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_process  = s1_valid_r && (!slot_fire || out_free);
  assign out_load    = s1_process && slot_fire;
  assign in_ch.ready = !s1_valid_r || s1_process;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r.status_bits <= in_ch.status_bits;
      s1_req_r.partner_ack <= in_ch.partner_ack;
      s1_req_r.rx_byte     <= in_ch.rx_byte;
    end
  end

  fshe_slot u_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (s1_req_r),
    .apply (s1_process),
    .fire  (slot_fire),
    .res   (slot_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= slot_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_byte     = out_res_r.tx_byte;
  assign out_ch.rx_taken    = out_res_r.rx_taken;
  assign out_ch.ack_request = out_res_r.ack_request;
  assign out_ch.staged_byte = out_res_r.staged_byte;
  assign out_ch.windings    = out_res_r.windings;
  assign out_ch.speed_rpm   = out_res_r.speed_rpm;
  assign out_ch.progress    = out_res_r.progress;
  assign out_ch.tension     = out_res_r.tension;
  assign out_ch.frame_done  = out_res_r.frame_done;

  // checks
`include "framed_spi_handshake_exchanger_assert.svh"

  `FSHE_ASSERT_NOW(a_load_free, out_load, !out_valid_r || out_ch.ready)
  `FSHE_ASSERT_NOW(a_done_taken, out_valid_r && out_res_r.frame_done, out_res_r.rx_taken)
  `FSHE_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_process, s1_valid_r && $stable(s1_req_r))

endmodule

`default_nettype wire

FILE: rtl/fshe_slot.sv
// ---------------------------------------------------------------------------
// fshe_slot
// Prescaler, handshake exchange and receive frame store for one tick.
// ---------------------------------------------------------------------------
`default_nettype none

module fshe_slot (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fshe_pkg::cfg_t     cfg,
  input  wire fshe_pkg::in_req_t  req,
  input  wire logic               apply,
  output      logic               fire,
  output      fshe_pkg::out_res_t res
);

  localparam int unsigned LEN = fshe_pkg::FRAME_LEN;

  logic [15:0]     tick_count_r, tick_count_nxt;
  logic [7:0]      wait_count_r, wait_count_nxt;
  fshe_pkg::idx_t  byte_index_r, byte_index_nxt;
  logic            last_ack_r, last_ack_nxt;
  logic            request_r, request_nxt;
  fshe_pkg::byte_t rx_frame_r [LEN];
  fshe_pkg::byte_t rx_frame_nxt [LEN];
  fshe_pkg::byte_t rx_wr [LEN];
  fshe_pkg::byte_t staged_r, staged_nxt;
  fshe_pkg::word_t windings_r, windings_nxt;
  fshe_pkg::word_t speed_r, speed_nxt;
  fshe_pkg::word_t progress_r, progress_nxt;
  fshe_pkg::word_t tension_r, tension_nxt;

  logic [15:0]     tick_inc;
  logic [7:0]      wait_inc;
  logic            exch, take, done;
  fshe_pkg::byte_t byte0;
  logic [4:0]      idx_inc;

  // slot timing and exchange decision
  always_comb begin
    tick_inc = tick_count_r + 16'd1;
    wait_inc = wait_count_r + 8'd1;
    fire     = tick_inc > cfg.prescale_limit;
    exch     = fire && ((req.partner_ack != last_ack_r) || (wait_inc > cfg.timeout_limit));
    take     = exch && (byte_index_r < 4'(LEN));
  end

  // receive store write, reply frame check and index step
  always_comb begin
    for (int k = 0; k < LEN; k++) begin
      rx_wr[k] = (take && byte_index_r == 4'(k)) ? req.rx_byte : rx_frame_r[k];
    end
    done  = exch && (rx_wr[LEN-1] == fshe_pkg::RX_EOF);
    byte0 = done ? '0 : rx_wr[0];
    idx_inc = {1'b0, byte_index_r} + 5'd1;

    for (int k = 0; k < LEN; k++) begin
      rx_frame_nxt[k] = done ? '0 : rx_wr[k];
    end

    tick_count_nxt = fire ? '0 : tick_inc;
    wait_count_nxt = exch ? '0 : (fire ? wait_inc : wait_count_r);
    byte_index_nxt = byte_index_r;
    if (exch) begin
      if (byte0 == fshe_pkg::RX_SOF && idx_inc < 5'(LEN)) begin
        byte_index_nxt = idx_inc[3:0];
      end else begin
        byte_index_nxt = '0;
      end
    end
    last_ack_nxt = exch ? req.partner_ack : last_ack_r;
    request_nxt  = exch ? ~request_r : request_r;
    staged_nxt   = take ? fshe_pkg::frame_byte(byte_index_r, req.status_bits, cfg)
                        : staged_r;
    windings_nxt = done ? {rx_wr[1], rx_wr[2]} : windings_r;
    speed_nxt    = done ? {rx_wr[3], rx_wr[4]} : speed_r;
    progress_nxt = done ? {rx_wr[5], rx_wr[6]} : progress_r;
    tension_nxt  = done ? {rx_wr[7], rx_wr[8]} : tension_r;
  end

  // result of this slot
  always_comb begin
    res.tx_byte     = fshe_pkg::frame_byte(byte_index_nxt, req.status_bits, cfg);
    res.rx_taken    = take;
    res.ack_request = request_nxt;
    res.staged_byte = staged_nxt;
    res.windings    = windings_nxt;
    res.speed_rpm   = speed_nxt;
    res.progress    = progress_nxt;
    res.tension     = tension_nxt;
    res.frame_done  = done;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      wait_count_r <= '0;
      byte_index_r <= '0;
      last_ack_r   <= 1'b0;
      request_r    <= 1'b0;
      staged_r     <= '0;
      windings_r   <= '0;
      speed_r      <= '0;
      progress_r   <= '0;
      tension_r    <= '0;
      for (int k = 0; k < LEN; k++) begin
        rx_frame_r[k] <= '0;
      end
    end else if (apply) begin
      tick_count_r <= tick_count_nxt;
      wait_count_r <= wait_count_nxt;
      byte_index_r <= byte_index_nxt;
      last_ack_r   <= last_ack_nxt;
      request_r    <= request_nxt;
      staged_r     <= staged_nxt;
      windings_r   <= windings_nxt;
      speed_r      <= speed_nxt;
      progress_r   <= progress_nxt;
      tension_r    <= tension_nxt;
      for (int k = 0; k < LEN; k++) begin
        rx_frame_r[k] <= rx_frame_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire
